// File: rtl/sstf_pkg.sv
package sstf_pkg;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SERVE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic        command;
        logic [15:0] cylinder;
    } sstf_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] served_cylinder;
        logic [15:0] from_position;
        logic [15:0] movement;
        logic [31:0] total_movement;
        logic [4:0]  pending_left;
    } sstf_out_t;

    // strobes from the sequencer to the nearest-request tracker
    typedef struct packed {
        logic sample;
        logic first;
    } scan_ctl_t;

endpackage

// File: rtl/shortest_seek_first_scheduler_top.sv
// Channel  Direction  Handshake          Payload
// in       into       in_valid/in_stall   sstf_pkg::sstf_in_t
// out      out of     out_valid/out_stall sstf_pkg::sstf_out_t
// cfg      into       cfg_valid/cfg_ready start_head (16 bits)
//
// Add or serve on an empty table: the result passes through the result register into
// the output register, and the next input transaction is taken once it is loaded
// there. Serve with N pending: the single read port of the table is walked once to
// find the nearest entry and once more to close the gap it leaves.
// Reset clears count, head, total and control; table contents stay unknown and
// are only read below the count, so no clearing pass runs.
// A stalled result holds in the output register; the next item is still taken,
// and its result then waits with the input stalled.
module shortest_seek_first_scheduler_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CYL_BITS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sstf_pkg::sstf_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sstf_pkg::sstf_out_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);

    localparam int CW   = CYL_BITS;
    localparam int IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_SHIFT,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [CNTW-1:0]     count_reg;
    logic [CNTW-1:0]     ptr_reg;
    logic [CW-1:0]       head_reg;
    logic [31:0]         sum_reg;
    logic                served_reg;
    logic                rd_vld_reg;
    logic [IDXW-1:0]     rd_idx_reg;
    logic                out_valid_reg;

    sstf_pkg::sstf_out_t res_reg;
    sstf_pkg::sstf_out_t res_next;
    logic                res_load;
    sstf_pkg::sstf_out_t out_data_reg;
    logic                out_load;

    logic [CW-1:0]       mem [QUEUE_DEPTH];
    logic [CW-1:0]       rdata_reg;
    logic                rd_en;
    logic [IDXW-1:0]     rd_addr;
    logic                wr_en;
    logic [IDXW-1:0]     wr_addr;
    logic [CW-1:0]       wr_data;

    logic                accept;
    logic                is_add;
    logic                full;
    logic                pass_done;
    logic [CW+15:0]      cyl_ext;
    logic [CW-1:0]       cyl_in;
    logic [CW+15:0]      cfg_ext;
    logic [CW+15:0]      head_ext;
    logic [CW+15:0]      best_cyl_ext;
    logic [CW+15:0]      best_dist_ext;
    logic [CNTW+4:0]     cnt_ext;
    logic [CNTW+4:0]     cnt_dec_ext;
    logic [32:0]         sum_wide;
    logic [31:0]         sum_sat;

    sstf_pkg::scan_ctl_t scan_ctl;
    logic [IDXW-1:0]     best_idx;
    logic [CW-1:0]       best_cyl;
    logic [CW-1:0]       best_dist;

    always_comb
    begin
        accept    = in_valid && !in_stall;
        is_add    = (in_data.command == sstf_pkg::CMD_ADD);
        full      = (count_reg >= CNTW'(QUEUE_DEPTH));
        cyl_ext   = {{CW{1'b0}}, in_data.cylinder};
        cyl_in    = cyl_ext[CW-1:0];
        cfg_ext   = {{CW{1'b0}}, cfg_data};
        head_ext  = {16'b0, head_reg};
        best_cyl_ext  = {16'b0, best_cyl};
        best_dist_ext = {16'b0, best_dist};
        cnt_ext       = {5'b0, count_reg};
        cnt_dec_ext   = {5'b0, count_reg - CNTW'(1)};
        sum_wide  = {1'b0, sum_reg} + 33'(best_dist);
        sum_sat   = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

        rd_en     = ((state_reg == S_SCAN) || (state_reg == S_SHIFT)) && (ptr_reg < count_reg);
        rd_addr   = ptr_reg[IDXW-1:0];
        pass_done = !rd_en && !rd_vld_reg;

        if (state_reg == S_SHIFT)
        begin
            // move each later entry down by one
            wr_en   = rd_vld_reg;
            wr_addr = rd_idx_reg - IDXW'(1);
            wr_data = rdata_reg;
        end
        else
        begin
            wr_en   = accept && is_add && !full;
            wr_addr = count_reg[IDXW-1:0];
            wr_data = cyl_in;
        end

        scan_ctl.sample = (state_reg == S_SCAN) && rd_vld_reg;
        scan_ctl.first  = (rd_idx_reg == '0);

        res_load = 1'b0;
        res_next = res_reg;
        if (accept)
        begin
            res_load                 = 1'b1;
            res_next.served_cylinder = '0;
            res_next.from_position   = head_ext[15:0];
            res_next.movement        = '0;
            res_next.total_movement  = sum_reg;
            if (is_add)
            begin
                res_next.status       = full ? sstf_pkg::STATUS_FULL : sstf_pkg::STATUS_OK;
                res_next.pending_left = full ? cnt_ext[4:0] : 5'(cnt_ext + (CNTW + 5)'(1));
            end
            else
            begin
                res_next.status       = sstf_pkg::STATUS_EMPTY;
                res_next.pending_left = cnt_ext[4:0];
            end
        end
        else if (state_reg == S_PICK)
        begin
            res_load                 = 1'b1;
            res_next.status          = sstf_pkg::STATUS_OK;
            res_next.served_cylinder = best_cyl_ext[15:0];
            res_next.from_position   = head_ext[15:0];
            res_next.movement        = best_dist_ext[15:0];
            res_next.total_movement  = sum_sat;
            res_next.pending_left    = cnt_dec_ext[4:0];
        end

        out_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    end

    sstf_nearest #(
        .CW   (CW),
        .IDXW (IDXW)
    ) u_nearest (
        .clk       (clk),
        .ctl       (scan_ctl),
        .head      (head_reg),
        .cyl       (rdata_reg),
        .idx       (rd_idx_reg),
        .best_idx  (best_idx),
        .best_cyl  (best_cyl),
        .best_dist (best_dist)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            head_reg      <= '0;
            sum_reg       <= '0;
            served_reg    <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            rd_idx_reg <= rd_addr;
            if (rd_en)
            begin
                ptr_reg <= ptr_reg + CNTW'(1);
            end

            if (cfg_valid && cfg_ready && !served_reg)
            begin
                head_reg <= cfg_ext[CW-1:0];
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_add)
                        begin
                            if (!full)
                            begin
                                count_reg <= count_reg + CNTW'(1);
                            end
                            state_reg <= S_EMIT;
                        end
                        else if (count_reg == '0)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            ptr_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (pass_done)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    head_reg   <= best_cyl;
                    sum_reg    <= sum_sat;
                    served_reg <= 1'b1;
                    ptr_reg    <= CNTW'(best_idx) + CNTW'(1);
                    state_reg  <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (pass_done)
                    begin
                        count_reg <= count_reg - CNTW'(1);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(QUEUE_DEPTH))
        else $error("pending count above table depth");

    a_shift_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && wr_en) |-> (CNTW'(wr_addr) < count_reg))
        else $error("compaction write beyond pending entries");

    a_head_moves_to_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |=> (head_reg == $past(best_cyl)))
        else $error("head not moved to chosen request");

    a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (sum_reg >= $past(sum_reg)))
        else $error("movement total decreased");
`endif

endmodule

// File: rtl/sstf_nearest.sv
module sstf_nearest #(
    parameter int CW   = 16,
    parameter int IDXW = 4
) (
    input  logic                 clk,
    input  sstf_pkg::scan_ctl_t  ctl,
    input  logic [CW-1:0]        head,
    input  logic [CW-1:0]        cyl,
    input  logic [IDXW-1:0]      idx,
    output logic [IDXW-1:0]      best_idx,
    output logic [CW-1:0]        best_cyl,
    output logic [CW-1:0]        best_dist
);

    logic [IDXW-1:0] best_idx_reg;
    logic [CW-1:0]   best_cyl_reg;
    logic [CW-1:0]   best_dist_reg;
    logic [CW-1:0]   seek_len;
    logic            take;

    always_comb
    begin
        seek_len = (cyl >= head) ? (cyl - head) : (head - cyl);
        // strict compare keeps the earliest entry on a tie
        take = ctl.sample && (ctl.first || (seek_len < best_dist_reg));
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg  <= idx;
            best_cyl_reg  <= cyl;
            best_dist_reg <= seek_len;
        end
    end

    assign best_idx  = best_idx_reg;
    assign best_cyl  = best_cyl_reg;
    assign best_dist = best_dist_reg;

endmodule
